### rtl/core/pidtw_pkg.sv
// Shared types and constants for the PID controller with twiddle tuning.
`default_nettype none

package pidtw_pkg;

   // Fixed widths of the gain, step and configuration words.
   localparam int GAIN_WIDTH     = 16;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int COUNT_WIDTH    = 16;
   localparam int SCALE_WIDTH    = 16;

   // Fraction bits of the gains (Q4.12) and of the step scale (Q0.16).
   localparam int FRAC_SHIFT  = 12;
   localparam int SCALE_SHIFT = 16;

   // Reset values of the configuration registers.
   localparam logic [COUNT_WIDTH-1:0] WINDOW_RESET = 16'd100;
   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET  = 16'd3277;

   // Configuration register indexes.
   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_GAIN_P = 3'd0,
      CSR_GAIN_I = 3'd1,
      CSR_GAIN_D = 3'd2,
      CSR_WINDOW = 3'd3,
      CSR_SCALE  = 3'd4,
      CSR_TUNE   = 3'd5
   } csr_index_type;

   // Gain currently being tuned, in tuning order P, D, I.
   typedef enum logic [1:0] {
      TUNE_P = 2'd0,
      TUNE_D = 2'd1,
      TUNE_I = 2'd2
   } tune_index_type;

   // Tuning status that travels with each word down the pipeline.
   typedef struct packed {
      logic window_done;
      logic new_best;
   } tune_flags_type;

endpackage

`default_nettype wire

### rtl/core/pidtw_state.sv
// Controller state: configuration registers, integral, window totals and twiddle update.
`default_nettype none

module pidtw_state #(
   parameter int ERROR_WIDTH = 16,
   parameter int ACCUM_WIDTH = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      csr_write_enable,
   input  wire logic [pidtw_pkg::CSR_ADDR_WIDTH-1:0]      csr_index,
   input  wire logic [pidtw_pkg::CSR_DATA_WIDTH-1:0]      csr_data,
   input  wire logic                                      accept,
   input  wire logic signed [ERROR_WIDTH-1:0]             cte_sample,
   output logic signed [pidtw_pkg::GAIN_WIDTH-1:0]        gain_p_next,
   output logic signed [pidtw_pkg::GAIN_WIDTH-1:0]        gain_i_next,
   output logic signed [pidtw_pkg::GAIN_WIDTH-1:0]        gain_d_next,
   output logic signed [ACCUM_WIDTH-1:0]                  integral_next,
   output logic signed [ERROR_WIDTH:0]                    diff_next,
   output pidtw_pkg::tune_flags_type                      flags_next
);

   localparam int GW = pidtw_pkg::GAIN_WIDTH;
   localparam int CW = pidtw_pkg::COUNT_WIDTH;
   localparam int SCW = pidtw_pkg::SCALE_WIDTH;
   localparam int WIDE = ((ACCUM_WIDTH > ERROR_WIDTH) ? ACCUM_WIDTH : ERROR_WIDTH) + 1;
   localparam int PW = GW + SCW + 3;

   localparam logic signed [WIDE-1:0] INT_MAX =
      {{(WIDE-ACCUM_WIDTH+1){1'b0}}, {(ACCUM_WIDTH-1){1'b1}}};
   localparam logic signed [WIDE-1:0] INT_MIN =
      {{(WIDE-ACCUM_WIDTH+1){1'b1}}, {(ACCUM_WIDTH-1){1'b0}}};
   localparam logic [PW-1:0] SC_HALF =
      {{(PW-pidtw_pkg::SCALE_SHIFT){1'b0}}, 1'b1, {(pidtw_pkg::SCALE_SHIFT-1){1'b0}}};
   localparam logic [PW-1:0] SC_LOW = SC_HALF - PW'(1);

   // Saturate a widened gain or step back to 16 signed bits.
   function automatic logic signed [GW-1:0] sat_gain(input logic signed [GW+2:0] v);
      logic signed [GW+2:0] hi;
      logic signed [GW+2:0] lo;
      hi = {4'b0000, {(GW-1){1'b1}}};
      lo = {4'b1111, {(GW-1){1'b0}}};
      if (v > hi) begin
         return hi[GW-1:0];
      end else if (v < lo) begin
         return lo[GW-1:0];
      end
      return v[GW-1:0];
   endfunction

   // One tenth of a gain, rounded half away from zero, by reciprocal multiply.
   function automatic logic signed [GW-1:0] tenth_of(input logic signed [GW-1:0] g);
      logic [GW-1:0]   mag;
      logic [2*GW-1:0] prod;
      logic [GW-1:0]   quo;
      mag  = (g[GW-1] ? (~g + GW'(1)) : g) + GW'(5);
      prod = {{GW{1'b0}}, mag} * (2*GW)'(52429);
      quo  = {3'd0, prod[2*GW-1:19]};
      return g[GW-1] ? (~quo + GW'(1)) : quo;
   endfunction

   // Registers.
   logic signed [GW-1:0]          gain_p_ff, gain_p_in;
   logic signed [GW-1:0]          gain_i_ff, gain_i_in;
   logic signed [GW-1:0]          gain_d_ff, gain_d_in;
   logic signed [GW-1:0]          step_p_ff, step_p_in;
   logic signed [GW-1:0]          step_i_ff, step_i_in;
   logic signed [GW-1:0]          step_d_ff, step_d_in;
   logic signed [ACCUM_WIDTH-1:0] integral_ff, integral_in;
   logic signed [ERROR_WIDTH-1:0] prev_ff, prev_in;
   logic [ACCUM_WIDTH-1:0]        total_ff, total_in;
   logic [ACCUM_WIDTH-1:0]        best_ff, best_in;
   logic [CW-1:0]                 count_ff, count_in;
   pidtw_pkg::tune_index_type     tune_ff, tune_in;
   logic                          added_ff, added_in;
   logic                          subbed_ff, subbed_in;
   logic [CW-1:0]                 window_ff, window_in;
   logic [SCW-1:0]                scale_ff, scale_in;
   logic                          tune_en_ff, tune_en_in;

   // Datapath signals.
   logic signed [WIDE-1:0]        integral_sum;
   logic signed [ACCUM_WIDTH-1:0] integral_sat;
   logic [ERROR_WIDTH-1:0]        error_mag;
   logic [WIDE-1:0]               total_sum;
   logic [ACCUM_WIDTH-1:0]        total_new;
   logic [CW-1:0]                 count_inc;
   logic                          window_close;
   logic                          is_best;
   pidtw_pkg::tune_index_type     tune_eff;
   pidtw_pkg::tune_index_type     tune_next;
   logic signed [GW-1:0]          step_cur;
   logic signed [GW-1:0]          gain_cur;
   logic signed [PW-1:0]          step_prod;
   logic signed [PW-1:0]          step_rnd;
   logic signed [GW+2:0]          delta;
   logic signed [GW-1:0]          step_grow;
   logic signed [GW-1:0]          step_shrink;
   logic signed [GW-1:0]          step_use;
   logic signed [GW-1:0]          gain_new;
   logic signed [GW-1:0]          step_new;
   logic                          added_eff;
   logic                          subbed_eff;
   logic                          added_new;
   logic                          subbed_new;

   // Saturating integral and exact derivative.
   assign integral_sum = {{(WIDE-ACCUM_WIDTH){integral_ff[ACCUM_WIDTH-1]}}, integral_ff}
                       + {{(WIDE-ERROR_WIDTH){cte_sample[ERROR_WIDTH-1]}}, cte_sample};
   assign integral_sat = (integral_sum > INT_MAX) ? INT_MAX[ACCUM_WIDTH-1:0] :
                         (integral_sum < INT_MIN) ? INT_MIN[ACCUM_WIDTH-1:0] :
                         integral_sum[ACCUM_WIDTH-1:0];
   assign diff_next = {cte_sample[ERROR_WIDTH-1], cte_sample}
                    - {prev_ff[ERROR_WIDTH-1], prev_ff};

   // Window error total, saturating at all ones, and window end detection.
   assign error_mag = cte_sample[ERROR_WIDTH-1] ? (~cte_sample + ERROR_WIDTH'(1)) : cte_sample;
   assign total_sum = {{(WIDE-ACCUM_WIDTH){1'b0}}, total_ff}
                    + {{(WIDE-ERROR_WIDTH){1'b0}}, error_mag};
   assign total_new = (total_sum[WIDE-1:ACCUM_WIDTH] != '0) ? {ACCUM_WIDTH{1'b1}} :
                      total_sum[ACCUM_WIDTH-1:0];
   assign count_inc    = count_ff + CW'(1);
   assign window_close = tune_en_ff && (count_inc == window_ff);
   assign is_best      = window_close && (total_new < best_ff);

   // Select the gain and step under tuning; an out-of-range index acts as P.
   always_comb begin
      case (tune_ff)
         pidtw_pkg::TUNE_D: begin
            tune_eff  = pidtw_pkg::TUNE_D;
            tune_next = pidtw_pkg::TUNE_I;
            step_cur  = step_d_ff;
            gain_cur  = gain_d_ff;
         end
         pidtw_pkg::TUNE_I: begin
            tune_eff  = pidtw_pkg::TUNE_I;
            tune_next = pidtw_pkg::TUNE_P;
            step_cur  = step_i_ff;
            gain_cur  = gain_i_ff;
         end
         default: begin
            tune_eff  = pidtw_pkg::TUNE_P;
            tune_next = pidtw_pkg::TUNE_D;
            step_cur  = step_p_ff;
            gain_cur  = gain_p_ff;
         end
      endcase
   end

   // Step scaled by the Q0.16 factor, rounded half away from zero.
   assign step_prod = step_cur * $signed({1'b0, scale_ff});
   assign step_rnd  = step_prod + (step_prod[PW-1] ? SC_LOW : SC_HALF);
   assign delta     = step_rnd[pidtw_pkg::SCALE_SHIFT+GW+2:pidtw_pkg::SCALE_SHIFT];
   assign step_grow   = sat_gain({{3{step_cur[GW-1]}}, step_cur} + delta);
   assign step_shrink = sat_gain({{3{step_cur[GW-1]}}, step_cur} - delta);

   // Twiddle decision: a new best grows the step and restarts the add/subtract cycle.
   always_comb begin
      added_eff  = is_best ? 1'b0 : added_ff;
      subbed_eff = is_best ? 1'b0 : subbed_ff;
      step_use   = is_best ? step_grow : step_cur;
      gain_new   = gain_cur;
      step_new   = step_use;
      added_new  = added_eff;
      subbed_new = subbed_eff;
      if (!added_eff && !subbed_eff) begin
         gain_new  = sat_gain({{3{gain_cur[GW-1]}}, gain_cur} + {{3{step_use[GW-1]}}, step_use});
         added_new = 1'b1;
      end else if (added_eff && !subbed_eff) begin
         gain_new   = sat_gain({{3{gain_cur[GW-1]}}, gain_cur} - {{3{step_use[GW-1]}}, step_use});
         subbed_new = 1'b1;
      end else begin
         step_new = step_shrink;
      end
   end

   // Next state from the accepted word and from configuration writes.
   always_comb begin
      gain_p_in   = gain_p_ff;
      gain_i_in   = gain_i_ff;
      gain_d_in   = gain_d_ff;
      step_p_in   = step_p_ff;
      step_i_in   = step_i_ff;
      step_d_in   = step_d_ff;
      integral_in = integral_ff;
      prev_in     = prev_ff;
      total_in    = total_ff;
      best_in     = best_ff;
      count_in    = count_ff;
      tune_in     = tune_ff;
      added_in    = added_ff;
      subbed_in   = subbed_ff;
      window_in   = window_ff;
      scale_in    = scale_ff;
      tune_en_in  = tune_en_ff;
      if (accept) begin
         integral_in = integral_sat;
         prev_in     = cte_sample;
         if (tune_en_ff) begin
            total_in = window_close ? '0 : total_new;
            count_in = window_close ? '0 : count_inc;
            if (window_close) begin
               if (is_best) begin
                  best_in = total_new;
               end
               tune_in   = tune_next;
               added_in  = added_new;
               subbed_in = subbed_new;
               case (tune_eff)
                  pidtw_pkg::TUNE_D: begin
                     gain_d_in = gain_new;
                     step_d_in = step_new;
                  end
                  pidtw_pkg::TUNE_I: begin
                     gain_i_in = gain_new;
                     step_i_in = step_new;
                  end
                  default: begin
                     gain_p_in = gain_new;
                     step_p_in = step_new;
                  end
               endcase
            end
         end
      end
      if (csr_write_enable) begin
         case (csr_index)
            pidtw_pkg::CSR_GAIN_P: begin
               gain_p_in = csr_data;
               step_p_in = tenth_of(csr_data);
            end
            pidtw_pkg::CSR_GAIN_I: begin
               gain_i_in = csr_data;
               step_i_in = tenth_of(csr_data);
            end
            pidtw_pkg::CSR_GAIN_D: begin
               gain_d_in = csr_data;
               step_d_in = tenth_of(csr_data);
            end
            pidtw_pkg::CSR_WINDOW: begin
               window_in = csr_data;
            end
            pidtw_pkg::CSR_SCALE: begin
               scale_in = csr_data;
            end
            pidtw_pkg::CSR_TUNE: begin
               tune_en_in = csr_data[0];
            end
            default: begin
               tune_en_in = tune_en_ff;
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff   <= '0;
         gain_i_ff   <= '0;
         gain_d_ff   <= '0;
         step_p_ff   <= '0;
         step_i_ff   <= '0;
         step_d_ff   <= '0;
         integral_ff <= '0;
         prev_ff     <= '0;
         total_ff    <= '0;
         best_ff     <= {ACCUM_WIDTH{1'b1}};
         count_ff    <= '0;
         tune_ff     <= pidtw_pkg::TUNE_P;
         added_ff    <= 1'b0;
         subbed_ff   <= 1'b0;
         window_ff   <= pidtw_pkg::WINDOW_RESET;
         scale_ff    <= pidtw_pkg::SCALE_RESET;
         tune_en_ff  <= 1'b0;
      end else begin
         gain_p_ff   <= gain_p_in;
         gain_i_ff   <= gain_i_in;
         gain_d_ff   <= gain_d_in;
         step_p_ff   <= step_p_in;
         step_i_ff   <= step_i_in;
         step_d_ff   <= step_d_in;
         integral_ff <= integral_in;
         prev_ff     <= prev_in;
         total_ff    <= total_in;
         best_ff     <= best_in;
         count_ff    <= count_in;
         tune_ff     <= tune_in;
         added_ff    <= added_in;
         subbed_ff   <= subbed_in;
         window_ff   <= window_in;
         scale_ff    <= scale_in;
         tune_en_ff  <= tune_en_in;
      end
   end

   // Operands for the steering datapath use the updated gains and integral.
   assign gain_p_next          = gain_p_in;
   assign gain_i_next          = gain_i_in;
   assign gain_d_next          = gain_d_in;
   assign integral_next        = integral_sat;
   assign flags_next.window_done = window_close;
   assign flags_next.new_best    = is_best;

endmodule

`default_nettype wire

### rtl/core/pidtw_mac.sv
// Steering datapath: operand, product and sum stages, rounding and saturation, output word.
`default_nettype none

module pidtw_mac #(
   parameter int ERROR_WIDTH = 16,
   parameter int ACCUM_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  load,
   output logic                                       load_ready,
   input  wire logic signed [pidtw_pkg::GAIN_WIDTH-1:0] gain_p,
   input  wire logic signed [pidtw_pkg::GAIN_WIDTH-1:0] gain_i,
   input  wire logic signed [pidtw_pkg::GAIN_WIDTH-1:0] gain_d,
   input  wire logic signed [ERROR_WIDTH-1:0]         cte_sample,
   input  wire logic signed [ACCUM_WIDTH-1:0]         integral,
   input  wire logic signed [ERROR_WIDTH:0]           diff,
   input  wire pidtw_pkg::tune_flags_type             flags,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [ERROR_WIDTH-1:0]              rsp_steering,
   output logic                                       rsp_window_done,
   output logic                                       rsp_new_best
);

   localparam int GW = pidtw_pkg::GAIN_WIDTH;
   localparam int FS = pidtw_pkg::FRAC_SHIFT;
   localparam int MW = (ACCUM_WIDTH > ERROR_WIDTH + 1) ? ACCUM_WIDTH : ERROR_WIDTH + 1;
   localparam int SW = GW + MW + 3;
   localparam int QW = SW - FS;

   localparam logic [SW-1:0] RND_HALF = {{(SW-FS){1'b0}}, 1'b1, {(FS-1){1'b0}}};
   localparam logic [SW-1:0] RND_LOW  = RND_HALF - SW'(1);
   localparam logic signed [QW-1:0] Q_MAX = {{(QW-ERROR_WIDTH+1){1'b0}}, {(ERROR_WIDTH-1){1'b1}}};
   localparam logic signed [QW-1:0] Q_MIN = {{(QW-ERROR_WIDTH+1){1'b1}}, {(ERROR_WIDTH-1){1'b0}}};

   // Stage valids and flow control.
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, vo_ff, vo_in;
   logic rdy1, rdy2, rdy3, rdyo;

   // Stage one: operands.
   logic signed [GW-1:0]          gp1_ff, gi1_ff, gd1_ff;
   logic signed [ERROR_WIDTH-1:0] e1_ff;
   logic signed [ACCUM_WIDTH-1:0] int1_ff;
   logic signed [ERROR_WIDTH:0]   diff1_ff;
   pidtw_pkg::tune_flags_type     fl1_ff, fl2_ff, fl3_ff, flo_ff;

   // Stage two: products.
   logic signed [GW+ERROR_WIDTH-1:0] pp_ff, pp_in;
   logic signed [GW+ACCUM_WIDTH-1:0] pi_ff, pi_in;
   logic signed [GW+ERROR_WIDTH:0]   pd_ff, pd_in;

   // Stage three and output.
   logic signed [SW-1:0]          sum_ff, sum_in;
   logic signed [SW-1:0]          neg_sum;
   logic signed [SW-1:0]          rnd_sum;
   logic signed [QW-1:0]          quo;
   logic signed [ERROR_WIDTH-1:0] steer_ff, steer_in;

   // A stage takes a new word when it is empty or its word moves on.
   assign rdyo = !vo_ff || !rsp_stall;
   assign rdy3 = !v3_ff || rdyo;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign load_ready = rdy1;

   assign v1_in = rdy1 ? load  : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign vo_in = rdyo ? v3_ff : vo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   // Three products, one per gain.
   assign pp_in = gp1_ff * e1_ff;
   assign pi_in = gi1_ff * int1_ff;
   assign pd_in = gd1_ff * diff1_ff;

   // Exact sum of the products.
   assign sum_in = {{(SW-GW-ERROR_WIDTH){pp_ff[GW+ERROR_WIDTH-1]}}, pp_ff}
                 + {{(SW-GW-ACCUM_WIDTH){pi_ff[GW+ACCUM_WIDTH-1]}}, pi_ff}
                 + {{(SW-GW-ERROR_WIDTH-1){pd_ff[GW+ERROR_WIDTH]}}, pd_ff};

   // Negate, drop the gain fraction rounding half away from zero, then saturate.
   assign neg_sum  = -sum_ff;
   assign rnd_sum  = neg_sum + (neg_sum[SW-1] ? RND_LOW : RND_HALF);
   assign quo      = rnd_sum[SW-1:FS];
   assign steer_in = (quo > Q_MAX) ? Q_MAX[ERROR_WIDTH-1:0] :
                     (quo < Q_MIN) ? Q_MIN[ERROR_WIDTH-1:0] :
                     quo[ERROR_WIDTH-1:0];

   // Payload registers advance with their valids.
   always_ff @(posedge clock) begin
      if (rdy1 && load) begin
         gp1_ff   <= gain_p;
         gi1_ff   <= gain_i;
         gd1_ff   <= gain_d;
         e1_ff    <= cte_sample;
         int1_ff  <= integral;
         diff1_ff <= diff;
         fl1_ff   <= flags;
      end
      if (rdy2 && v1_ff) begin
         pp_ff  <= pp_in;
         pi_ff  <= pi_in;
         pd_ff  <= pd_in;
         fl2_ff <= fl1_ff;
      end
      if (rdy3 && v2_ff) begin
         sum_ff <= sum_in;
         fl3_ff <= fl2_ff;
      end
      if (rdyo && v3_ff) begin
         steer_ff <= steer_in;
         flo_ff   <= fl3_ff;
      end
   end

   assign rsp_valid       = vo_ff;
   assign rsp_steering    = steer_ff;
   assign rsp_window_done = flo_ff.window_done;
   assign rsp_new_best    = flo_ff.new_best;

endmodule

`default_nettype wire

### rtl/core/pid_controller_with_twiddle_tuning_top.sv
// Top level of the PID controller with twiddle gain tuning.
// A result word passes the operand, product, sum and output registers after its
// error word is accepted. Throughput: one word per cycle unless rsp_stall holds
// the output; the integral, window and twiddle state update in the single cycle
// in which a word is accepted; multiply and sum run in the pipeline behind it.
// Reset is synchronous and active high; it clears all pipeline valids and state
// and loads the configuration defaults, and the block accepts words right after.
`default_nettype none

module pid_controller_with_twiddle_tuning_top #(
   parameter int ERROR_WIDTH = 16,
   parameter int ACCUM_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [pidtw_pkg::CSR_ADDR_WIDTH-1:0] csr_index,
   input  wire logic [pidtw_pkg::CSR_DATA_WIDTH-1:0] csr_data,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [ERROR_WIDTH-1:0]        req_cte_sample,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [ERROR_WIDTH-1:0]             rsp_steering,
   output logic                                      rsp_window_done,
   output logic                                      rsp_new_best
);

   logic                                        accept;
   logic                                        load_ready;
   logic signed [pidtw_pkg::GAIN_WIDTH-1:0]     gain_p_next;
   logic signed [pidtw_pkg::GAIN_WIDTH-1:0]     gain_i_next;
   logic signed [pidtw_pkg::GAIN_WIDTH-1:0]     gain_d_next;
   logic signed [ACCUM_WIDTH-1:0]               integral_next;
   logic signed [ERROR_WIDTH:0]                 diff_next;
   pidtw_pkg::tune_flags_type                   flags_next;

   // A word is taken whenever the first pipeline stage can hold it.
   assign req_stall = !load_ready;
   assign accept    = req_valid && load_ready;

   // Controller state and twiddle tuning.
   pidtw_state #(
      .ERROR_WIDTH (ERROR_WIDTH),
      .ACCUM_WIDTH (ACCUM_WIDTH)
   ) u_state (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .accept           (accept),
      .cte_sample       (req_cte_sample),
      .gain_p_next      (gain_p_next),
      .gain_i_next      (gain_i_next),
      .gain_d_next      (gain_d_next),
      .integral_next    (integral_next),
      .diff_next        (diff_next),
      .flags_next       (flags_next)
   );

   // Steering multiply, sum and output word.
   pidtw_mac #(
      .ERROR_WIDTH (ERROR_WIDTH),
      .ACCUM_WIDTH (ACCUM_WIDTH)
   ) u_mac (
      .clock           (clock),
      .reset           (reset),
      .load            (accept),
      .load_ready      (load_ready),
      .gain_p          (gain_p_next),
      .gain_i          (gain_i_next),
      .gain_d          (gain_d_next),
      .cte_sample      (req_cte_sample),
      .integral        (integral_next),
      .diff            (diff_next),
      .flags           (flags_next),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_steering    (rsp_steering),
      .rsp_window_done (rsp_window_done),
      .rsp_new_best    (rsp_new_best)
   );

endmodule

`default_nettype wire

### sim/pidtw_steering_checker.sv
// Checker that predicts and compares every steering word of the PID twiddle controller.
`timescale 1ns / 100ps

module pidtw_steering_checker
   import pidtw_pkg::*;
#(
   parameter int ERROR_WIDTH = 16,
   parameter int ACCUM_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [CSR_ADDR_WIDTH-1:0]     csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_data,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [ERROR_WIDTH-1:0] req_cte_sample,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [ERROR_WIDTH-1:0] rsp_steering,
   input  logic                          rsp_window_done,
   input  logic                          rsp_new_best,
   output int                            mismatch_count,
   output int                            words_outstanding
);

   localparam longint TOTAL_LIMIT = (longint'(1) <<< ACCUM_WIDTH) - 1;

   typedef struct {
      logic signed [ERROR_WIDTH-1:0] steering;
      logic                          window_done;
      logic                          new_best;
   } steering_word_t;

   // Configuration copy.
   logic [COUNT_WIDTH-1:0] window_length;
   logic [SCALE_WIDTH-1:0] step_scale;
   logic                   tuning_enable;

   // Controller and tuner state; gains and steps are indexed in tuning order P, D, I.
   longint                 tuned_gain [3];
   longint                 step_size [3];
   longint                 integral;
   longint                 last_error;
   longint                 window_total;
   longint                 best_total;
   logic [COUNT_WIDTH-1:0] window_fill;
   tune_index_type         tuning_gain;
   logic                   step_added;
   logic                   step_subtracted;

   steering_word_t predicted_words [$];

   function automatic longint clamp_signed(input longint value, input int width);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (width - 1)) - 1;
      lo = -hi - 1;
      return value > hi ? hi : (value < lo ? lo : value);
   endfunction

   // Shift right rounding to nearest, ties away from zero.
   function automatic longint round_shift(input longint value, input int shift);
      longint mag;
      mag = ((value < 0 ? -value : value) + (longint'(1) <<< (shift - 1))) >>> shift;
      return value < 0 ? -mag : mag;
   endfunction

   function automatic longint scaled_step(input longint step);
      return round_shift(step * longint'(step_scale), SCALE_SHIFT);
   endfunction

   // Loading a gain also seeds its step with a tenth of it, rounded away from zero.
   function automatic void load_gain(input tune_index_type which, input logic [15:0] data);
      longint mag;
      tuned_gain[which] = longint'(signed'(data));
      mag = ((tuned_gain[which] < 0 ? -tuned_gain[which] : tuned_gain[which]) + 5) / 10;
      step_size[which] = tuned_gain[which] < 0 ? -mag : mag;
   endfunction

   function automatic void reset_model();
      window_length   = WINDOW_RESET;
      step_scale      = SCALE_RESET;
      tuning_enable   = 1'b0;
      tuned_gain      = '{0, 0, 0};
      step_size       = '{0, 0, 0};
      integral        = 0;
      last_error      = 0;
      window_total    = 0;
      best_total      = TOTAL_LIMIT;
      window_fill     = '0;
      tuning_gain     = TUNE_P;
      step_added      = 1'b0;
      step_subtracted = 1'b0;
   endfunction

   function automatic void load_register(input csr_index_type index,
                                         input logic [CSR_DATA_WIDTH-1:0] data);
      case (index)
         CSR_GAIN_P: load_gain(TUNE_P, data);
         CSR_GAIN_I: load_gain(TUNE_I, data);
         CSR_GAIN_D: load_gain(TUNE_D, data);
         CSR_WINDOW: window_length = data;
         CSR_SCALE:  step_scale = data;
         CSR_TUNE:   tuning_enable = data[0];
         default: ;
      endcase
   endfunction

   // Advances the controller by one error sample and returns the steering word it gives.
   function automatic steering_word_t predict_steering(
      input logic signed [ERROR_WIDTH-1:0] sample);
      steering_word_t word;
      tune_index_type sel;
      longint         err;
      longint         diff;
      longint         total;
      longint         acc;
      err = longint'(sample);
      diff = err - last_error;
      integral = clamp_signed(integral + err, ACCUM_WIDTH);
      last_error = err;
      word.window_done = 1'b0;
      word.new_best = 1'b0;

      if (tuning_enable) begin
         total = window_total + (err < 0 ? -err : err);
         window_total = total > TOTAL_LIMIT ? TOTAL_LIMIT : total;
         window_fill = window_fill + 1'b1;
         if (window_fill == window_length) begin
            word.window_done = 1'b1;
            case (tuning_gain)
               TUNE_D:  sel = TUNE_D;
               TUNE_I:  sel = TUNE_I;
               default: sel = TUNE_P;
            endcase

            // A strictly better window grows the step and restarts the add/subtract cycle.
            if (window_total < best_total) begin
               word.new_best = 1'b1;
               best_total = window_total;
               step_size[sel] = clamp_signed(step_size[sel] + scaled_step(step_size[sel]),
                                             GAIN_WIDTH);
               step_added = 1'b0;
               step_subtracted = 1'b0;
            end

            if (!step_added && !step_subtracted) begin
               tuned_gain[sel] = clamp_signed(tuned_gain[sel] + step_size[sel], GAIN_WIDTH);
               step_added = 1'b1;
            end else if (step_added && !step_subtracted) begin
               tuned_gain[sel] = clamp_signed(tuned_gain[sel] - step_size[sel], GAIN_WIDTH);
               step_subtracted = 1'b1;
            end else begin
               step_size[sel] = clamp_signed(step_size[sel] - scaled_step(step_size[sel]),
                                             GAIN_WIDTH);
            end

            case (sel)
               TUNE_P:  tuning_gain = TUNE_D;
               TUNE_D:  tuning_gain = TUNE_I;
               default: tuning_gain = TUNE_P;
            endcase
            window_total = 0;
            window_fill = '0;
         end
      end

      // Steering uses the gains as they stand after any tuning step of this sample.
      acc = tuned_gain[TUNE_P] * err + tuned_gain[TUNE_I] * integral
          + tuned_gain[TUNE_D] * diff;
      acc = clamp_signed(round_shift(-acc, FRAC_SHIFT), ERROR_WIDTH);
      word.steering = acc[ERROR_WIDTH-1:0];
      return word;
   endfunction

   initial reset_model();

   // Track register writes and accepted words on both channels.
   always @(posedge clock) begin : monitor
      steering_word_t predicted;
      if (reset) begin
         reset_model();
         predicted_words.delete();
         mismatch_count <= 0;
         words_outstanding <= 0;
      end else begin
         if (csr_write_enable)
            load_register(csr_index_type'(csr_index), csr_data);
         if (req_valid && !req_stall)
            predicted_words.push_back(predict_steering(req_cte_sample));
         if (rsp_valid && !rsp_stall) begin
            if (predicted_words.size() == 0) begin
               if (mismatch_count < 10)
                  $display("Steering word with none predicted: steering %0d done %0b best %0b",
                           rsp_steering, rsp_window_done, rsp_new_best);
               mismatch_count <= mismatch_count + 1;
            end else begin
               predicted = predicted_words.pop_front();
               if (rsp_steering !== predicted.steering
                   || rsp_window_done !== predicted.window_done
                   || rsp_new_best !== predicted.new_best) begin
                  if (mismatch_count < 10)
                     $display("Steering word mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                              predicted.steering, predicted.window_done, predicted.new_best,
                              rsp_steering, rsp_window_done, rsp_new_best);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         words_outstanding <= predicted_words.size();
      end
   end

endmodule

### sim/pid_controller_with_twiddle_tuning_top_tb.sv
// Testbench top: drives error words and register writes into the PID twiddle controller.
`timescale 1ns / 100ps

module pid_controller_with_twiddle_tuning_top_tb;
   import pidtw_pkg::*;

   localparam int ERROR_WIDTH = 16;
   localparam int ACCUM_WIDTH = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_COUNT = 14;
   localparam int PHASE_WORDS = 68;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]     csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]     csr_data = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [ERROR_WIDTH-1:0] req_cte_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [ERROR_WIDTH-1:0] rsp_steering;
   logic                          rsp_window_done;
   logic                          rsp_new_best;

   int   mismatch_count;
   int   words_outstanding;
   int   cycle_count = 0;
   logic idling_on = 1'b1;
   logic hold_long = 1'b0;

   // Loose mirror of the window counter, used only to pick window lengths that close.
   int   window_fill = 0;
   int   cur_window = WINDOW_RESET;
   logic cur_tune = 1'b0;

   pid_controller_with_twiddle_tuning_top #(
      .ERROR_WIDTH(ERROR_WIDTH),
      .ACCUM_WIDTH(ACCUM_WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cte_sample(req_cte_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_steering(rsp_steering),
      .rsp_window_done(rsp_window_done),
      .rsp_new_best(rsp_new_best)
   );

   pidtw_steering_checker #(
      .ERROR_WIDTH(ERROR_WIDTH),
      .ACCUM_WIDTH(ACCUM_WIDTH)
   ) steering_check (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cte_sample(req_cte_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_steering(rsp_steering),
      .rsp_window_done(rsp_window_done),
      .rsp_new_best(rsp_new_best),
      .mismatch_count(mismatch_count),
      .words_outstanding(words_outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: stall before taking each word, at random or long on hold_long.
   initial begin : result_drain
      int hold;
      forever begin
         hold = 0;
         if (hold_long) begin
            hold = 120;
            hold_long = 1'b0;
         end else if (idling_on) begin
            hold = $urandom_range(0, 15);
         end
         repeat (hold) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_WINDOW) cur_window = data;
      if (index == CSR_TUNE) cur_tune = data[0];
   endtask

   task automatic send_error(input logic signed [ERROR_WIDTH-1:0] sample);
      int gap;
      gap = idling_on ? $urandom_range(0, 15) : 0;
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cte_sample <= sample;
      do @(posedge clock); while (req_stall);
      if (cur_tune) begin
         window_fill = (window_fill + 1) % 65536;
         if (window_fill == cur_window) window_fill = 0;
      end
   endtask

   // Stop offering words and wait until every predicted word has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (words_outstanding != 0);
      @(posedge clock);
   endtask

   function automatic logic [15:0] random_gain();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 8192) - 4096);
         2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom_range(0, 1024));
      endcase
   endfunction

   initial begin : stimulus
      int                            phase;
      int                            n;
      int                            cap;
      int                            mag;
      logic [15:0]                   window;
      logic signed [ERROR_WIDTH-1:0] sample;

      do @(posedge clock); while (reset);

      // Plain mode with extreme gains: saturation of the steering at its positive limit.
      write_register(CSR_GAIN_P, 16'h7FFF);
      write_register(CSR_GAIN_I, 16'h8000);
      write_register(CSR_GAIN_D, 16'h0001);
      send_error(16'sh7FFF);
      send_error(-16'sh8000);
      send_error(16'sh0000);
      send_error(-16'sh0001);
      send_error(16'sh0001);
      send_error(16'sh7FFF);
      send_error(16'sh7FFF);
      send_error(-16'sh8000);
      wait_drained();

      // Window of one at full scale: first window is a new best, then add, subtract
      // and shrink as the totals rise, then a fresh best restarts the cycle.
      write_register(CSR_WINDOW, 16'd1);
      write_register(CSR_SCALE, 16'hFFFF);
      write_register(CSR_TUNE, 16'h0001);
      send_error(16'sd300);
      send_error(16'sd400);
      send_error(-16'sd500);
      send_error(16'sd600);
      send_error(16'sd0);
      send_error(-16'sh8000);
      send_error(16'sd7);
      wait_drained();

      // Longest window, then lowered below the count so the count has to wrap.
      write_register(CSR_SCALE, 16'h0000);
      write_register(CSR_WINDOW, 16'hFFFF);
      send_error(16'sd11);
      send_error(-16'sd12);
      send_error(16'sd13);
      wait_drained();
      write_register(CSR_WINDOW, 16'd2);
      send_error(16'sd14);
      send_error(-16'sd15);
      wait_drained();
      write_register(CSR_WINDOW, 16'd7);
      send_error(16'sd16);
      send_error(16'sd17);
      wait_drained();

      // Random phases; error magnitudes shrink from phase to phase so new bests keep coming.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_drained();
         if ($urandom_range(0, 1) || phase == 0) write_register(CSR_GAIN_P, random_gain());
         if ($urandom_range(0, 1) || phase == 0) write_register(CSR_GAIN_I, random_gain());
         if ($urandom_range(0, 1) || phase == 0) write_register(CSR_GAIN_D, random_gain());
         if ($urandom_range(0, 1) || phase == 0) begin
            case ($urandom_range(0, 3))
               0: write_register(CSR_SCALE, 16'h0000);
               1: write_register(CSR_SCALE, 16'hFFFF);
               default: write_register(CSR_SCALE, 16'($urandom));
            endcase
         end
         if (phase > 0 && window_fill > 1 && $urandom_range(0, 7) == 0)
            window = 16'($urandom_range(1, window_fill - 1));
         else
            window = 16'(window_fill + $urandom_range(1, 12));
         write_register(CSR_WINDOW, window);
         write_register(CSR_TUNE, {15'($urandom), 1'($urandom_range(0, 3) != 0)});

         idling_on = (phase % 4 != 2);
         cap = 32767 >> phase;
         for (n = 0; n < PHASE_WORDS; n++) begin
            // The receiver holds off while words keep coming, so the block backs up.
            if (phase == 2 && n == 20) hold_long = 1'b1;
            if (phase == 5 && n == 34) wait_drained();
            if ($urandom_range(0, 7) == 0) begin
               sample = ERROR_WIDTH'($urandom);
            end else begin
               mag = $urandom_range(0, cap);
               sample = ERROR_WIDTH'(mag);
               if ($urandom_range(0, 1)) sample = -sample;
            end
            send_error(sample);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0 && words_outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

### filelist.f
rtl/core/pidtw_pkg.sv
rtl/core/pidtw_state.sv
rtl/core/pidtw_mac.sv
rtl/core/pid_controller_with_twiddle_tuning_top.sv
sim/pidtw_steering_checker.sv
sim/pid_controller_with_twiddle_tuning_top_tb.sv
